### rtl/core/yse_pkg.sv
// ----------------------------------------------------------------------------
// yse_pkg
// shared constants, luma knee tables and control types for the skin classifier
// ----------------------------------------------------------------------------
package yse_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // luma clamp and knees
    localparam int Y_MIN   = 16;
    localparam int Y_MAX   = 235;
    localparam int K_LO    = 125;
    localparam int K_HI    = 188;
    localparam int SPAN_LO = K_LO - Y_MIN;
    localparam int SPAN_HI = Y_MAX - K_HI;

    // chroma means at the high knee
    localparam int CB_KNEE = 108;
    localparam int CR_KNEE = 154;

    // mean shifts and width floors of the knee curves
    localparam int SH_CB    = 10;
    localparam int SH_CR_HI = 22;
    localparam int WB_LO    = 23;
    localparam int WR_LO    = 20;
    localparam int WB_HI    = 14;
    localparam int WR_HI    = 10;

    // rotation, signed q1.14
    localparam int COS_Q14  = -13414;
    localparam int SIN_Q14  = 9407;
    localparam int ANG_BITS = 14;

    // ellipse test: (ux*1400)^2 + (uy*2539)^2 <= (35546 * 2^F)^2
    localparam int     AX_SCALE = 1400;
    localparam int     BY_SCALE = 2539;
    localparam longint RHS_BASE = 64'd1263518116;

    // chroma lanes
    localparam int LANES   = 2;
    localparam int LANE_CB = 0;
    localparam int LANE_CR = 1;

    typedef enum logic [1:0] {
        TS_MEAN_CB,
        TS_MEAN_CR,
        TS_WID_CB,
        TS_WID_CR
    } t_tab_sel;

    typedef logic [31:0] t_tab [256];

    // per-pixel control that rides along the datapath
    typedef struct packed {
        logic             pass;
        logic [LANES-1:0] neg;
    } t_side;

    // decimal constant given in hundredths, to q.frac, ties rounded up
    function automatic longint qh(input longint h, input int frac);
        return ((h <<< frac) + 64'sd50) / 64'sd100;
    endfunction

    // luma-indexed knee table, clamp folded in; middle band holds one
    function automatic t_tab knee_tab(input int frac, input t_tab_sel sel);
        t_tab   tab;
        longint one;
        longint wcb;
        longint wcr;
        longint y;
        longint v;
        one = 64'sd1 <<< frac;
        wcb = qh(4697, frac);
        wcr = qh(3876, frac);
        for (int i = 0; i < 256; i++) begin
            y = (i < Y_MIN) ? Y_MIN : ((i > Y_MAX) ? Y_MAX : i);
            v = one;
            if (y < K_LO) begin
                case (sel)
                    TS_MEAN_CB: v = CB_KNEE * one
                                  + ((K_LO - y) * SH_CB * one + SPAN_LO / 2) / SPAN_LO;
                    TS_MEAN_CR: v = CR_KNEE * one
                                  - ((K_LO - y) * SH_CB * one + SPAN_LO / 2) / SPAN_LO;
                    TS_WID_CB:  v = WB_LO * one
                                  + ((y - Y_MIN) * (wcb - WB_LO * one) + SPAN_LO / 2) / SPAN_LO;
                    TS_WID_CR:  v = WR_LO * one
                                  + ((y - Y_MIN) * (wcr - WR_LO * one) + SPAN_LO / 2) / SPAN_LO;
                    default:    v = one;
                endcase
            end else if (y > K_HI) begin
                case (sel)
                    TS_MEAN_CB: v = CB_KNEE * one
                                  + ((y - K_HI) * SH_CB * one + SPAN_HI / 2) / SPAN_HI;
                    TS_MEAN_CR: v = CR_KNEE * one
                                  + ((y - K_HI) * SH_CR_HI * one + SPAN_HI / 2) / SPAN_HI;
                    TS_WID_CB:  v = WB_HI * one
                                  + ((Y_MAX - y) * (wcb - WB_HI * one) + SPAN_HI / 2) / SPAN_HI;
                    TS_WID_CR:  v = WR_HI * one
                                  + ((Y_MAX - y) * (wcr - WR_HI * one) + SPAN_HI / 2) / SPAN_HI;
                    default:    v = one;
                endcase
            end
            tab[i] = 32'(v);
        end
        return tab;
    endfunction

endpackage

### rtl/core/yse_pix_if.sv
// ----------------------------------------------------------------------------
// yse_pix_if
// pixel request channel: luma and chroma pair with valid/ready
// ----------------------------------------------------------------------------
interface yse_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    output ready);
endinterface

### rtl/core/yse_flag_if.sv
// ----------------------------------------------------------------------------
// yse_flag_if
// classification request channel: one skin flag with valid/ready
// ----------------------------------------------------------------------------
interface yse_flag_if;
    logic valid;
    logic ready;
    logic is_skin;

    modport source (output valid, output is_skin, input ready);
    modport sink   (input valid, input is_skin, output ready);
endinterface

### rtl/core/yse_norm.sv
// ----------------------------------------------------------------------------
// yse_norm
// luma knee lookup, chroma offset, width scaling and divider operand setup
// ----------------------------------------------------------------------------
module yse_norm #(
    parameter int FRAC_BITS = yse_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [7:0]                                   i_luma,
    input  logic [7:0]                                   i_cb,
    input  logic [7:0]                                   i_cr,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [yse_pkg::LANES-1:0][2*FRAC_BITS+15:0]  o_dvd,
    output logic [yse_pkg::LANES-1:0][FRAC_BITS+5:0]     o_dvs,
    output logic [yse_pkg::LANES-1:0][7:0]               o_chroma,
    output yse_pkg::t_side                               o_side
);
    import yse_pkg::*;

    localparam int NST = 4;
    localparam int MW  = FRAC_BITS + 8;
    localparam int WLW = FRAC_BITS + 6;
    localparam int DW  = FRAC_BITS + 9;
    localparam int AW  = FRAC_BITS + 8;
    localparam int PW  = 2 * FRAC_BITS + 14;
    localparam int NW  = 2 * FRAC_BITS + 16;

    localparam t_tab TAB_MB = knee_tab(FRAC_BITS, TS_MEAN_CB);
    localparam t_tab TAB_MR = knee_tab(FRAC_BITS, TS_MEAN_CR);
    localparam t_tab TAB_WB = knee_tab(FRAC_BITS, TS_WID_CB);
    localparam t_tab TAB_WR = knee_tab(FRAC_BITS, TS_WID_CR);

    localparam logic [WLW-1:0] WF_CB = WLW'(qh(4697, FRAC_BITS));
    localparam logic [WLW-1:0] WF_CR = WLW'(qh(3876, FRAC_BITS));

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    logic [NST-1:0] w_vin;

    // stage 1: table lookup
    logic [LANES-1:0][MW-1:0]  r1_mean, n1_mean;
    logic [LANES-1:0][WLW-1:0] r1_wid,  n1_wid;
    logic [LANES-1:0][7:0]     r1_chr,  n1_chr;
    logic                      r1_pass, n1_pass;

    // stage 2: offset magnitude
    logic signed [DW-1:0]      w_diff [LANES];
    logic [LANES-1:0][AW-1:0]  r2_mag, n2_mag;
    logic [LANES-1:0][WLW-1:0] r2_wid;
    logic [LANES-1:0][7:0]     r2_chr;
    t_side                     r2_side, n2_side;

    // stage 3: scale by the full width
    logic [LANES-1:0][PW-1:0]  r3_prod, n3_prod;
    logic [LANES-1:0][WLW-1:0] r3_wid;
    logic [LANES-1:0][7:0]     r3_chr;
    t_side                     r3_side;

    // stage 4: rounding bias
    logic [LANES-1:0][NW-1:0]  r4_dvd, n4_dvd;
    logic [LANES-1:0][WLW-1:0] r4_wid;
    logic [LANES-1:0][7:0]     r4_chr;
    t_side                     r4_side;

    assign w_vin = {r_vld[NST-2:0], i_valid};

    for (genvar k = 0; k < NST; k++) begin : g_en
        if (k == NST - 1) begin : g_last
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_comb begin
        n1_mean[LANE_CB] = TAB_MB[i_luma][MW-1:0];
        n1_mean[LANE_CR] = TAB_MR[i_luma][MW-1:0];
        n1_wid[LANE_CB]  = TAB_WB[i_luma][WLW-1:0];
        n1_wid[LANE_CR]  = TAB_WR[i_luma][WLW-1:0];
        n1_chr[LANE_CB]  = i_cb;
        n1_chr[LANE_CR]  = i_cr;
        // between the knees chroma passes unchanged
        n1_pass = (i_luma >= 8'(K_LO)) && (i_luma <= 8'(K_HI));
    end

    always_comb begin
        n2_side.pass = r1_pass;
        for (int l = 0; l < LANES; l++) begin
            w_diff[l] = signed'({1'b0, r1_chr[l], {FRAC_BITS{1'b0}}})
                      - signed'({1'b0, r1_mean[l]});
            n2_side.neg[l] = w_diff[l][DW-1];
            n2_mag[l] = n2_side.neg[l] ? AW'(-w_diff[l]) : AW'(w_diff[l]);
        end
    end

    always_comb begin
        n3_prod[LANE_CB] = r2_mag[LANE_CB] * WF_CB;
        n3_prod[LANE_CR] = r2_mag[LANE_CR] * WF_CR;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n4_dvd[l] = NW'(r3_prod[l]) + NW'(r3_wid[l] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mean <= n1_mean;
            r1_wid  <= n1_wid;
            r1_chr  <= n1_chr;
            r1_pass <= n1_pass;
        end
        if (w_en[1]) begin
            r2_mag  <= n2_mag;
            r2_wid  <= r1_wid;
            r2_chr  <= r1_chr;
            r2_side <= n2_side;
        end
        if (w_en[2]) begin
            r3_prod <= n3_prod;
            r3_wid  <= r2_wid;
            r3_chr  <= r2_chr;
            r3_side <= r2_side;
        end
        if (w_en[3]) begin
            r4_dvd  <= n4_dvd;
            r4_wid  <= r3_wid;
            r4_chr  <= r3_chr;
            r4_side <= r3_side;
        end
    end

    assign o_ready  = w_en[0];
    assign o_valid  = r_vld[NST-1];
    assign o_dvd    = r4_dvd;
    assign o_dvs    = r4_wid;
    assign o_chroma = r4_chr;
    assign o_side   = r4_side;

endmodule

### rtl/core/yse_div.sv
// ----------------------------------------------------------------------------
// yse_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module yse_div #(
    parameter int FRAC_BITS = yse_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [yse_pkg::LANES-1:0][2*FRAC_BITS+15:0]  i_dvd,
    input  logic [yse_pkg::LANES-1:0][FRAC_BITS+5:0]     i_dvs,
    input  logic [yse_pkg::LANES-1:0][7:0]               i_chroma,
    input  yse_pkg::t_side                               i_side,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [yse_pkg::LANES-1:0][FRAC_BITS+11:0]    o_quo,
    output logic [yse_pkg::LANES-1:0][7:0]               o_chroma,
    output yse_pkg::t_side                               o_side
);
    import yse_pkg::*;

    localparam int NW  = 2 * FRAC_BITS + 16;
    localparam int WLW = FRAC_BITS + 6;
    localparam int QW  = FRAC_BITS + 12;
    localparam int XW  = NW + 2;

    logic [QW-1:0] r_vld;
    logic [QW-1:0] w_en;
    logic [QW-1:0] w_vin;

    logic [LANES-1:0][XW-1:0]  r_rem  [QW];
    logic [LANES-1:0][XW-1:0]  w_rem  [QW];
    logic [LANES-1:0][QW-1:0]  r_quo  [QW];
    logic [LANES-1:0][QW-1:0]  w_quo  [QW];
    logic [LANES-1:0][WLW-1:0] r_dvs  [QW];
    logic [LANES-1:0][WLW-1:0] w_dvs  [QW];
    logic [LANES-1:0][7:0]     r_chr  [QW];
    logic [LANES-1:0][7:0]     w_chr  [QW];
    t_side                     r_side [QW];
    t_side                     w_side [QW];

    assign w_vin = {r_vld[QW-2:0], i_valid};

    for (genvar k = 0; k < QW; k++) begin : g_en
        if (k == QW - 1) begin : g_last
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic [LANES-1:0][XW-1:0] w_sub;
        logic [LANES-1:0]         w_ge;
        logic [LANES-1:0][XW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (s == 0) begin : g_head
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign w_rem[s][l] = XW'(i_dvd[l]);
            end
            assign w_quo[s]  = '0;
            assign w_dvs[s]  = i_dvs;
            assign w_chr[s]  = i_chroma;
            assign w_side[s] = i_side;
        end else begin : g_body
            assign w_rem[s]  = r_rem[s-1];
            assign w_quo[s]  = r_quo[s-1];
            assign w_dvs[s]  = r_dvs[s-1];
            assign w_chr[s]  = r_chr[s-1];
            assign w_side[s] = r_side[s-1];
        end

        // trial subtract of the divisor aligned to quotient bit B
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sub[l]    = XW'(w_dvs[s][l]) << B;
                w_ge[l]     = w_rem[s][l] >= w_sub[l];
                n_rem[l]    = w_ge[l] ? (w_rem[s][l] - w_sub[l]) : w_rem[s][l];
                n_quo[l]    = w_quo[s][l];
                n_quo[l][B] = w_ge[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_dvs[s]  <= w_dvs[s];
                r_chr[s]  <= w_chr[s];
                r_side[s] <= w_side[s];
            end
        end
    end

    assign o_ready  = w_en[0];
    assign o_valid  = r_vld[QW-1];
    assign o_quo    = r_quo[QW-1];
    assign o_chroma = r_chr[QW-1];
    assign o_side   = r_side[QW-1];

    a_rem_cb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW-1] && !r_side[QW-1].pass
            |-> r_rem[QW-1][LANE_CB] < XW'(r_dvs[QW-1][LANE_CB]))
        else $error("cb remainder not below divisor at divider exit");

    a_rem_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW-1] && !r_side[QW-1].pass
            |-> r_rem[QW-1][LANE_CR] < XW'(r_dvs[QW-1][LANE_CR]))
        else $error("cr remainder not below divisor at divider exit");

    a_dvs_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_dvs[0][LANE_CB] != '0) && (r_dvs[0][LANE_CR] != '0))
        else $error("zero width entered the divider");

endmodule

### rtl/core/yse_ell.sv
// ----------------------------------------------------------------------------
// yse_ell
// re-centring, rotation and exact ellipse membership test
// ----------------------------------------------------------------------------
module yse_ell #(
    parameter int FRAC_BITS = yse_pkg::FRAC_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [yse_pkg::LANES-1:0][FRAC_BITS+11:0]  i_quo,
    input  logic [yse_pkg::LANES-1:0][7:0]             i_chroma,
    input  yse_pkg::t_side                             i_side,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic                                       o_is_skin
);
    import yse_pkg::*;

    localparam int NST = 8;
    localparam int QW  = FRAC_BITS + 12;
    localparam int UW  = FRAC_BITS + 14;
    localparam int PW  = UW + 15;
    localparam int SW  = PW + 1;
    localparam int XRW = SW - ANG_BITS;
    localparam int DXW = XRW + 1;
    localparam int UXW = XRW;
    localparam int PXW = FRAC_BITS + 17;
    localparam int SQW = 2 * PXW;
    localparam int LW  = SQW + 1;

    localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
    localparam longint P_CB_L = qh(10938, FRAC_BITS);
    localparam longint P_CR_L = qh(15202, FRAC_BITS);

    localparam logic signed [UW-1:0] P_OFF [LANES] = '{UW'(P_CB_L), UW'(P_CR_L)};
    localparam logic signed [UW-1:0] K_OFF [LANES] = '{UW'(CB_KNEE * ONE_L - P_CB_L),
                                                       UW'(CR_KNEE * ONE_L - P_CR_L)};
    localparam logic signed [14:0]   COS_C   = 15'(COS_Q14);
    localparam logic signed [14:0]   SIN_C   = 15'(SIN_Q14);
    localparam logic signed [SW-1:0] RND_POS = SW'(64'sd1 <<< (ANG_BITS - 1));
    localparam logic signed [SW-1:0] RND_NEG = SW'((64'sd1 <<< (ANG_BITS - 1)) - 64'sd1);
    localparam logic signed [DXW-1:0] DX_OFF = DXW'(qh(160, FRAC_BITS));
    localparam logic signed [DXW-1:0] DY_OFF = DXW'(qh(241, FRAC_BITS));
    localparam logic [UXW-1:0] ABOUND = UXW'((64'd2539 << FRAC_BITS) / 64'd100);
    localparam logic [UXW-1:0] BBOUND = UXW'(64'd14 << FRAC_BITS);
    localparam logic [LW-1:0]  RHS    = LW'(RHS_BASE) << (2 * FRAC_BITS);

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    logic [NST-1:0] w_vin;

    logic signed [UW-1:0]  w_q [LANES];
    logic signed [UW-1:0]  w_c [LANES];
    logic signed [UW-1:0]  r1_u [LANES];
    logic signed [UW-1:0]  n1_u [LANES];

    logic signed [PW-1:0]  r2_pcu, r2_psv, r2_psu, r2_pcv;
    logic signed [PW-1:0]  n2_pcu, n2_psv, n2_psu, n2_pcv;

    logic signed [SW-1:0]  r3_sx, r3_st, n3_sx, n3_st;

    logic signed [SW-1:0]  w_rx, w_rt;
    logic signed [XRW-1:0] r4_x, r4_t, n4_x, n4_t;

    logic signed [DXW-1:0] w_dx, w_dy;
    logic [UXW-1:0]        r5_ux, r5_uy, n5_ux, n5_uy;

    logic [PXW-1:0]        r6_px, r6_py, n6_px, n6_py;
    logic                  r6_in, n6_in;

    logic [SQW-1:0]        r7_sqx, r7_sqy, n7_sqx, n7_sqy;
    logic                  r7_in;

    logic                  r8_skin, n8_skin;

    assign w_vin = {r_vld[NST-2:0], i_valid};

    for (genvar k = 0; k < NST; k++) begin : g_en
        if (k == NST - 1) begin : g_last
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // signed quotient plus knee centre, or raw chroma between the knees, minus the ellipse frame centre
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_q[l] = signed'(UW'(i_quo[l]));
            w_c[l] = signed'(UW'({i_chroma[l], {FRAC_BITS{1'b0}}}));
            if (i_side.pass) begin
                n1_u[l] = w_c[l] - P_OFF[l];
            end else if (i_side.neg[l]) begin
                n1_u[l] = K_OFF[l] - w_q[l];
            end else begin
                n1_u[l] = K_OFF[l] + w_q[l];
            end
        end
    end

    always_comb begin
        n2_pcu = r1_u[LANE_CB] * COS_C;
        n2_psv = r1_u[LANE_CR] * SIN_C;
        n2_psu = r1_u[LANE_CB] * SIN_C;
        n2_pcv = r1_u[LANE_CR] * COS_C;
    end

    always_comb begin
        n3_sx = SW'(r2_pcu) + SW'(r2_psv);
        n3_st = SW'(r2_pcv) - SW'(r2_psu);
    end

    // drop the angle bits, nearest with ties away from zero
    always_comb begin
        w_rx = r3_sx + (r3_sx[SW-1] ? RND_NEG : RND_POS);
        w_rt = r3_st + (r3_st[SW-1] ? RND_NEG : RND_POS);
        n4_x = XRW'(w_rx >>> ANG_BITS);
        n4_t = XRW'(w_rt >>> ANG_BITS);
    end

    always_comb begin
        w_dx  = DXW'(r4_x) - DX_OFF;
        w_dy  = DXW'(r4_t) - DY_OFF;
        n5_ux = w_dx[DXW-1] ? UXW'(-w_dx) : UXW'(w_dx);
        n5_uy = w_dy[DXW-1] ? UXW'(-w_dy) : UXW'(w_dy);
    end

    // bounding box first keeps the squares narrow
    always_comb begin
        n6_in = (r5_ux <= ABOUND) && (r5_uy <= BBOUND);
        n6_px = r5_ux[FRAC_BITS+4:0] * 11'(AX_SCALE);
        n6_py = r5_uy[FRAC_BITS+4:0] * 12'(BY_SCALE);
    end

    always_comb begin
        n7_sqx = r6_px * r6_px;
        n7_sqy = r6_py * r6_py;
    end

    always_comb begin
        n8_skin = r7_in && ((LW'(r7_sqx) + LW'(r7_sqy)) <= RHS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_u <= n1_u;
        end
        if (w_en[1]) begin
            r2_pcu <= n2_pcu;
            r2_psv <= n2_psv;
            r2_psu <= n2_psu;
            r2_pcv <= n2_pcv;
        end
        if (w_en[2]) begin
            r3_sx <= n3_sx;
            r3_st <= n3_st;
        end
        if (w_en[3]) begin
            r4_x <= n4_x;
            r4_t <= n4_t;
        end
        if (w_en[4]) begin
            r5_ux <= n5_ux;
            r5_uy <= n5_uy;
        end
        if (w_en[5]) begin
            r6_px <= n6_px;
            r6_py <= n6_py;
            r6_in <= n6_in;
        end
        if (w_en[6]) begin
            r7_sqx <= n7_sqx;
            r7_sqy <= n7_sqy;
            r7_in  <= r6_in;
        end
        if (w_en[7]) begin
            r8_skin <= n8_skin;
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[NST-1];
    assign o_is_skin = r8_skin;

endmodule

### rtl/core/ycbcr_skin_ellipse_classifier.sv
// ----------------------------------------------------------------------------
// ycbcr_skin_ellipse_classifier
// per-pixel skin flag from the nonlinear ycbcr elliptical skin model
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  -------   ---   -------------   -------------------------------------
//  i_pix     in    valid / ready   luma[7:0] chroma_blue[7:0] chroma_red[7:0]
//  o_skin    out   valid / ready   is_skin
//
//  one pixel per clock while o_skin is not stalled; the restoring divider
//  spends one stage per quotient bit
//  i_rst_n is synchronous and active low; it empties every stage
//  each stage keeps its own valid bit and advances when it is empty or the
//  stage after it moves, so a stall at o_skin fills bubbles upstream first
//  and i_pix keeps taking pixels until the first stage is full
//
module ycbcr_skin_ellipse_classifier #(
    parameter int FRAC_BITS = yse_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    yse_pix_if.sink   i_pix,
    yse_flag_if.source o_skin
);
    import yse_pkg::*;

    localparam int NW  = 2 * FRAC_BITS + 16;
    localparam int WLW = FRAC_BITS + 6;
    localparam int QW  = FRAC_BITS + 12;

    // front end to divider
    logic                           w_nd_valid;
    logic                           w_nd_ready;
    logic [LANES-1:0][NW-1:0]       w_nd_dvd;
    logic [LANES-1:0][WLW-1:0]      w_nd_dvs;
    logic [LANES-1:0][7:0]          w_nd_chr;
    t_side                          w_nd_side;

    // divider to ellipse test
    logic                           w_de_valid;
    logic                           w_de_ready;
    logic [LANES-1:0][QW-1:0]       w_de_quo;
    logic [LANES-1:0][7:0]          w_de_chr;
    t_side                          w_de_side;

    // knee lookup, chroma offset from the luma mean, scale by full width,
    // then numerator with half the local width added for rounding
    yse_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_luma   (i_pix.luma),
        .i_cb     (i_pix.chroma_blue),
        .i_cr     (i_pix.chroma_red),
        .o_valid  (w_nd_valid),
        .i_ready  (w_nd_ready),
        .o_dvd    (w_nd_dvd),
        .o_dvs    (w_nd_dvs),
        .o_chroma (w_nd_chr),
        .o_side   (w_nd_side)
    );

    // magnitude divided by the luma-dependent width, both chroma lanes
    yse_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_nd_valid),
        .o_ready  (w_nd_ready),
        .i_dvd    (w_nd_dvd),
        .i_dvs    (w_nd_dvs),
        .i_chroma (w_nd_chr),
        .i_side   (w_nd_side),
        .o_valid  (w_de_valid),
        .i_ready  (w_de_ready),
        .o_quo    (w_de_quo),
        .o_chroma (w_de_chr),
        .o_side   (w_de_side)
    );

    // sign restore and re-centre, rotate by theta, then the ellipse check;
    // pixels between the knees bypass the quotient and use raw chroma
    yse_ell #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ell (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_de_valid),
        .o_ready   (w_de_ready),
        .i_quo     (w_de_quo),
        .i_chroma  (w_de_chr),
        .i_side    (w_de_side),
        .o_valid   (o_skin.valid),
        .i_ready   (o_skin.ready),
        .o_is_skin (o_skin.is_skin)
    );

    // the whole pipeline is empty the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_skin.valid)
        else $error("result offered right after reset");

endmodule

### sim/yse_skin_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yse_skin_checker
// watches both channels of the skin classifier, works out the skin flag of
// every accepted pixel and compares it with the flags in arrival order
// ----------------------------------------------------------------------------
module yse_skin_checker #(
    parameter int FRAC_BITS = yse_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    yse_pix_if   i_pix,
    yse_flag_if  i_skin,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_skin_count
);

    localparam longint LUMA_FLOOR = 16;
    localparam longint LUMA_CEIL  = 235;
    localparam longint KNEE_LOW   = 125;
    localparam longint KNEE_HIGH  = 188;
    localparam longint SPAN_LOW   = KNEE_LOW - LUMA_FLOOR;
    localparam longint SPAN_HIGH  = LUMA_CEIL - KNEE_HIGH;
    localparam longint CB_CENTRE  = 108;
    localparam longint CR_CENTRE  = 154;
    localparam longint ROT_COS    = -13414;
    localparam longint ROT_SIN    = 9407;
    localparam longint A_SQ_E4    = 6446521;
    localparam longint B_SQ       = 196;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       skin;
    } t_pix_verdict;

    t_pix_verdict verdict_q[$];
    int           fail_total;
    int           checked_total;
    int           skin_total;

    // nearest, ties away from zero; den is always positive
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic longint hundredths_to_q(input longint h);
        return ((h <<< FRAC_BITS) + 50) / 100;
    endfunction

    function automatic longint rescale(input longint c, input longint mean,
                                       input longint wfull, input longint wloc);
        return div_nearest((c - mean) * wfull, wloc);
    endfunction

    function automatic logic predict_skin(input logic [7:0] luma_in,
                                          input logic [7:0] cb_in,
                                          input logic [7:0] cr_in);
        longint one;
        longint y;
        longint cb;
        longint cr;
        longint wcb;
        longint wcr;
        longint shift;
        longint mb;
        longint mr;
        longint wb;
        longint wr;
        longint u;
        longint v;
        longint dx;
        longint dy;
        longint ux;
        longint uy;
        longint a_lim;
        longint lhs;
        longint rhs;
        one = 64'sd1 <<< FRAC_BITS;
        y   = luma_in;
        cb  = cb_in;
        cr  = cr_in;
        cb  = cb * one;
        cr  = cr * one;
        wcb = hundredths_to_q(4697);
        wcr = hundredths_to_q(3876);
        if (y < LUMA_FLOOR) y = LUMA_FLOOR;
        if (y > LUMA_CEIL) y = LUMA_CEIL;

        if (y < KNEE_LOW) begin
            shift = div_nearest((KNEE_LOW - y) * 10 * one, SPAN_LOW);
            wb = 23 * one + div_nearest((y - LUMA_FLOOR) * (wcb - 23 * one), SPAN_LOW);
            wr = 20 * one + div_nearest((y - LUMA_FLOOR) * (wcr - 20 * one), SPAN_LOW);
            cb = rescale(cb, CB_CENTRE * one + shift, wcb, wb) + CB_CENTRE * one;
            cr = rescale(cr, CR_CENTRE * one - shift, wcr, wr) + CR_CENTRE * one;
        end else if (y > KNEE_HIGH) begin
            mb = CB_CENTRE * one + div_nearest((y - KNEE_HIGH) * 10 * one, SPAN_HIGH);
            mr = CR_CENTRE * one + div_nearest((y - KNEE_HIGH) * 22 * one, SPAN_HIGH);
            wb = 14 * one + div_nearest((LUMA_CEIL - y) * (wcb - 14 * one), SPAN_HIGH);
            wr = 10 * one + div_nearest((LUMA_CEIL - y) * (wcr - 10 * one), SPAN_HIGH);
            cb = rescale(cb, mb, wcb, wb) + CB_CENTRE * one;
            cr = rescale(cr, mr, wcr, wr) + CR_CENTRE * one;
        end

        u  = cb - hundredths_to_q(10938);
        v  = cr - hundredths_to_q(15202);
        dx = div_nearest(ROT_COS * u + ROT_SIN * v, 64'sd1 <<< 14) - hundredths_to_q(160);
        dy = div_nearest(-ROT_SIN * u + ROT_COS * v, 64'sd1 <<< 14) - hundredths_to_q(241);
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;

        // bounding box first, keeps the squares small
        a_lim = (64'sd2539 <<< FRAC_BITS) / 100;
        if (ux > a_lim || uy > 14 * one) return 1'b0;
        lhs = ux * ux * (10000 * B_SQ) + uy * uy * A_SQ_E4;
        rhs = (A_SQ_E4 * B_SQ) <<< (2 * FRAC_BITS);
        return (lhs <= rhs);
    endfunction

    always @(posedge i_clk) begin
        t_pix_verdict head;
        t_pix_verdict fresh;
        if (!i_rst_n) begin
            verdict_q.delete();
            fail_total    = 0;
            checked_total = 0;
            skin_total    = 0;
        end else begin
            // result side first, so a pixel never answers itself
            if (i_skin.valid && i_skin.ready) begin
                checked_total++;
                if (i_skin.is_skin === 1'b1) skin_total++;
                if (verdict_q.size() == 0) begin
                    fail_total++;
                    $display("%t unexpected flag: expected none, actual is_skin=%b",
                             $time, i_skin.is_skin);
                end else begin
                    head = verdict_q.pop_front();
                    if (i_skin.is_skin !== head.skin) begin
                        fail_total++;
                        $display("%t flag mismatch y=%0d cb=%0d cr=%0d: expected %b actual %b",
                                 $time, head.luma, head.cb, head.cr, head.skin,
                                 i_skin.is_skin);
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                fresh.luma = i_pix.luma;
                fresh.cb   = i_pix.chroma_blue;
                fresh.cr   = i_pix.chroma_red;
                fresh.skin = predict_skin(i_pix.luma, i_pix.chroma_blue, i_pix.chroma_red);
                verdict_q.push_back(fresh);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= verdict_q.size();
        o_checked    <= checked_total;
        o_skin_count <= skin_total;
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// skin classifier bench: directed corner pixels, then random pixels weighted
// toward the skin region, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC          = yse_pkg::FRAC_BITS_DEF;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_PIXELS = 1227;
    // last stretch of the random part runs with no idling
    localparam int CALM_PIXELS   = 150;
    // long output hold-off, well past the pipeline depth
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AFTER    = 60;
    // pipeline depth is FRAC + 24, give it some slack when draining
    localparam int DRAIN_CYCLES  = FRAC + 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_N    = 23;

    // directed pixels as {luma, cb, cr}
    localparam logic [23:0] DIRECTED [DIRECTED_N] = '{
        {8'd0,   8'd0,   8'd0},     // all fields at the bottom
        {8'd255, 8'd255, 8'd255},   // all fields at the top
        {8'd15,  8'd108, 8'd154},   // luma under the clamp
        {8'd16,  8'd108, 8'd154},   // luma at the clamp floor
        {8'd17,  8'd120, 8'd140},
        {8'd124, 8'd110, 8'd152},   // just below the low knee
        {8'd125, 8'd110, 8'd152},   // on the low knee, chroma passes
        {8'd126, 8'd109, 8'd152},
        {8'd150, 8'd109, 8'd152},   // middle band, ellipse centre
        {8'd187, 8'd100, 8'd160},
        {8'd188, 8'd100, 8'd160},   // on the high knee
        {8'd189, 8'd108, 8'd154},   // just above the high knee
        {8'd234, 8'd108, 8'd154},
        {8'd235, 8'd108, 8'd154},   // luma at the clamp ceiling
        {8'd236, 8'd108, 8'd154},   // luma over the clamp
        {8'd255, 8'd0,   8'd255},   // far outside, strong rescale
        {8'd150, 8'd0,   8'd255},   // far outside the box
        {8'd150, 8'd255, 8'd0},
        {8'd150, 8'd85,  8'd160},   // toward the major axis end
        {8'd150, 8'd130, 8'd140},
        {8'd150, 8'd110, 8'd166},   // toward the minor axis end
        {8'd60,  8'd128, 8'd128},   // neutral grey, dark
        {8'd200, 8'd95,  8'd175}    // bright, reddish
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm;

    int unsigned cycle_count;
    int          pixels_sent;
    int          fail_count;
    int          pending;
    int          results_checked;
    int          skin_count;

    yse_pix_if  pix_ch ();
    yse_flag_if skin_ch ();

    ycbcr_skin_ellipse_classifier #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_skin  (skin_ch)
    );

    yse_skin_checker #(
        .FRAC_BITS (FRAC)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_skin       (skin_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (results_checked),
        .o_skin_count (skin_count)
    );

    always #2 i_clk = ~i_clk;

    // offer one pixel request and hold it until the block takes it,
    // then, outside the calm stretch, maybe leave a gap
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb,
                              input logic [7:0] cr);
        pix_ch.valid       <= 1'b1;
        pix_ch.luma        <= y;
        pix_ch.chroma_blue <= cb;
        pix_ch.chroma_red  <= cr;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pixels_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
        pixels_sent        = 0;
        pix_ch.valid       <= 1'b0;
        pix_ch.luma        <= 8'd0;
        pix_ch.chroma_blue <= 8'd0;
        pix_ch.chroma_red  <= 8'd0;
        calm               <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners of luma, knees and chroma
        for (int k = 0; k < DIRECTED_N; k++) begin
            send_pixel(DIRECTED[k][23:16], DIRECTED[k][15:8], DIRECTED[k][7:0]);
        end

        // random part: most pixels sit near the skin cluster so both
        // answers come up often, the rest span the whole cube
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            calm <= (n >= RANDOM_PIXELS - CALM_PIXELS);
            case ($urandom_range(0, 3))
                0: begin
                    y  = 8'($urandom_range(0, 255));
                    cb = 8'($urandom_range(0, 255));
                    cr = 8'($urandom_range(0, 255));
                end
                1: begin
                    y  = 8'($urandom_range(0, 255));
                    cb = 8'($urandom_range(85, 135));
                    cr = 8'($urandom_range(130, 180));
                end
                2: begin
                    // around the knees and the middle band
                    y  = 8'($urandom_range(110, 200));
                    cb = 8'($urandom_range(85, 135));
                    cr = 8'($urandom_range(130, 180));
                end
                default: begin
                    // deep in the rescaled bands, clamp ends included
                    y  = $urandom_range(0, 1) ? 8'($urandom_range(0, 60))
                                              : 8'($urandom_range(215, 255));
                    cb = 8'($urandom_range(70, 150));
                    cr = 8'($urandom_range(120, 190));
                end
            endcase
            send_pixel(y, cb, cr);
        end

        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixels across both knees, the clamp ends and the middle band",
                 pixels_sent);
        $display("%0d flags checked, %0d of them skin, with one %0d-cycle output hold-off",
                 results_checked, skin_count, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // result side: random stall bursts, one long hold-off that backs the
    // pipeline up into the input, and no stalls in the calm stretch
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        skin_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                skin_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                skin_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                skin_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

endmodule
